### src/mf3_pkg.sv
// mf3_pkg: shared types and constants for the 3x3 max filter.
// No dependencies; imported by max_filter_3x3.
`timescale 1ns / 1ps

package mf3_pkg;

  localparam int ROW_BITS       = 16;
  localparam int WCFG_BITS      = 11;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic [WCFG_BITS-1:0] WIDTH_RESET  = 11'd5;
  localparam logic [ROW_BITS-1:0]  HEIGHT_RESET = 16'd5;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WIDTH  = 1'd0,
    REG_HEIGHT = 1'd1
  } cfg_reg_t;

endpackage

### src/max_filter_3x3.sv
// max_filter_3x3: streaming 3x3 grayscale dilation with paired line-store RAM.
// Depends on mf3_pkg.
`timescale 1ns / 1ps

// Channel | Handshake                  | Payload
// --------+----------------------------+---------------------------------
// item    | item_valid / item_stall    | pixel_in, drain
// result  | result_valid / result_stall| pixel_out, frame_last
// cfg     | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item per clock while item_stall is low; an item's result goes via stage 1 to the result register.
// Throughput is set by the single line-store RAM (one read, one write a cycle).
// After reset a clearing pass zeroes all MAX_WIDTH RAM words; item_stall is high meanwhile.
// Each config write holds item_stall high for one cycle while size products settle.
// item_stall also rises when a result-bearing item waits on a stalled result register.

module max_filter_3x3
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [PIXEL_BITS-1:0]     pixel_in,
  input  logic                      drain,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [PIXEL_BITS-1:0]     pixel_out,
  output logic                      frame_last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int NW = CW + ROW_BITS;
  localparam int PW = WW + ROW_BITS;
  localparam int P  = PIXEL_BITS;

  // config
  logic [WCFG_BITS-1:0] cfg_width;
  logic [ROW_BITS-1:0]  cfg_height;
  logic                 cfg_fire;
  logic                 settle;

  logic [WW-1:0]       w_c;
  logic [ROW_BITS-1:0] h_c;
  logic [PW-1:0]       prod;
  logic [WW-1:0]       w_eff;
  logic [ROW_BITS-1:0] h_eff;
  logic [NW-1:0]       total;
  logic [NW-1:0]       base;
  logic [CW-1:0]       wm1;

  // position state
  logic [CW-1:0]       col, col_next;
  logic [ROW_BITS-1:0] row, row_next;
  logic [NW-1:0]       ocnt, ocnt_next;

  // stage 0
  logic          accept;
  logic          complete;
  logic [NW:0]   cnt_inc;
  logic          last;
  logic          pix_emit;
  logic          emit0;
  logic          work0;
  logic          border;
  logic          col_wrap;
  logic          tail;
  logic [NW-1:0] c_full;
  logic [CW-1:0] c_sel;
  logic [CW-1:0] rd_addr;
  logic          sel_b;

  // RAM and clearing
  logic [2*P-1:0] mem [MAX_WIDTH];
  logic [2*P-1:0] rd_q;
  logic           byp;
  logic [2*P-1:0] byp_q;
  logic           wr_en;
  logic [CW-1:0]  wr_addr;
  logic [2*P-1:0] wr_data;
  logic           clearing;
  logic [CW-1:0]  clr_addr;

  // stage 1
  logic          s1_valid;
  logic          s1_pix;
  logic          s1_emit;
  logic          s1_last;
  logic          s1_border;
  logic          s1_selb;
  logic [P-1:0]  s1_data;
  logic [CW-1:0] s1_addr;
  logic          s1_move;
  logic          out_free;

  logic [2*P-1:0] mem_word;
  logic [P-1:0]   top;
  logic [P-1:0]   mid;
  logic [P-1:0]   win [9];
  logic [P-1:0]   win_new [9];
  logic [P-1:0]   mx;
  logic [P-1:0]   res_val;

  // ---------------- config ----------------
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WIDTH_RESET;
      cfg_height <= HEIGHT_RESET;
      settle     <= 1'b1;
    end else begin
      settle <= cfg_fire;
      if (cfg_fire) begin
        case (cfg_index)
          REG_WIDTH:  cfg_width  <= cfg_data[WCFG_BITS-1:0];
          REG_HEIGHT: cfg_height <= cfg_data[ROW_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (cfg_width == '0) begin
      w_c = WW'(1);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(cfg_width);
    end
    h_c = (cfg_height == '0) ? ROW_BITS'(1) : cfg_height;
  end

  assign prod = PW'(w_c) * PW'(h_c);

  always_ff @(posedge clk) begin
    w_eff <= w_c;
    h_eff <= h_c;
    total <= NW'(prod);
    base  <= NW'(prod) - NW'(w_c);
    wm1   <= CW'(w_c - WW'(1));
  end

  // ---------------- stage 0 ----------------
  assign out_free   = !result_valid || !result_stall;
  assign s1_move    = s1_valid && (!s1_emit || out_free);
  assign item_stall = settle || clearing || (s1_valid && !s1_move);
  assign accept     = item_valid && !item_stall;

  assign complete = row >= h_eff;
  assign cnt_inc  = {1'b0, ocnt} + (NW + 1)'(1);
  assign last     = cnt_inc >= {1'b0, total};
  assign pix_emit = (row >= ROW_BITS'(2)) || (row == ROW_BITS'(1) && col != '0) ||
                    (row == '0 && WW'(col) > w_eff);
  assign emit0    = complete || (!drain && pix_emit);
  assign work0    = complete || !drain;
  assign border   = (row <= ROW_BITS'(1)) || (col <= CW'(1)) || (WW'(col) >= w_eff);
  assign col_wrap = (WW'(col) + WW'(1)) >= w_eff;

  assign tail    = ocnt >= base;
  assign c_full  = ocnt - base;
  assign c_sel   = (c_full >= NW'(w_eff)) ? wm1 : CW'(c_full);
  assign rd_addr = complete ? (tail ? c_sel : wm1) : col;
  assign sel_b   = complete && !tail;

  always_comb begin
    col_next  = col;
    row_next  = row;
    ocnt_next = ocnt;
    if (accept && work0) begin
      if (emit0) begin
        ocnt_next = last ? '0 : NW'(cnt_inc);
      end
      if (emit0 && last) begin
        col_next = '0;
        row_next = '0;
      end else if (!complete) begin
        if (col_wrap) begin
          col_next = '0;
          row_next = row + ROW_BITS'(1);
        end else begin
          col_next = col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      ocnt <= '0;
    end else begin
      col  <= col_next;
      row  <= row_next;
      ocnt <= ocnt_next;
    end
  end

  // ---------------- line-store RAM ----------------
  // word = {row before previous, previous row}
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + CW'(1);
      if (clr_addr == CW'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign wr_en   = clearing || (s1_move && s1_pix);
  assign wr_addr = clearing ? clr_addr : s1_addr;
  assign wr_data = clearing ? '0 : {mid, s1_data};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_q <= mem[rd_addr];
    end
  end

  // same-edge write to the address being read
  always_ff @(posedge clk) begin
    if (accept) begin
      byp   <= wr_en && (wr_addr == rd_addr);
      byp_q <= wr_data;
    end
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= work0;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix    <= !complete;
      s1_emit   <= emit0;
      s1_last   <= last;
      s1_border <= border;
      s1_selb   <= sel_b;
      s1_data   <= pixel_in;
      s1_addr   <= col;
    end
  end

  assign mem_word = byp ? byp_q : rd_q;
  assign top      = mem_word[2*P-1:P];
  assign mid      = mem_word[P-1:0];

  always_comb begin
    win_new[0] = win[1];
    win_new[1] = win[2];
    win_new[2] = top;
    win_new[3] = win[4];
    win_new[4] = win[5];
    win_new[5] = mid;
    win_new[6] = win[7];
    win_new[7] = win[8];
    win_new[8] = s1_data;
  end

  always_comb begin
    mx = win_new[0];
    for (int k = 1; k < 9; k++) begin
      if (win_new[k] > mx) begin
        mx = win_new[k];
      end
    end
  end

  always_comb begin
    if (s1_pix) begin
      res_val = s1_border ? win_new[4] : mx;
    end else begin
      res_val = s1_selb ? top : mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= '0;
      end
    end else if (s1_move && s1_pix) begin
      for (int k = 0; k < 9; k++) begin
        win[k] <= win_new[k];
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_move && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_emit) begin
      pixel_out  <= res_val;
      frame_last <= s1_last;
    end
  end

endmodule

### src/mf3_checker.sv
// mf3_checker: port-level assertions for max_filter_3x3, bound to the top level.
// No package dependency.
`timescale 1ns / 1ps

module mf3_checker #(
  parameter int PIXEL_BITS = 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_stall,
  input logic                  result_valid,
  input logic                  result_stall,
  input logic [PIXEL_BITS-1:0] pixel_out,
  input logic                  frame_last,
  input logic                  cfg_valid,
  input logic                  cfg_ready
);

  // RAM clearing blocks items, result register empties
  a_reset_state: assert property (@(posedge clk)
    rst |=> (item_stall && !result_valid))
    else $error("items not blocked or result pending after reset");

  // size products are registered after a register write, so items are blocked meanwhile
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> item_stall)
    else $error("item taken in the cycle after a config write");

  // a stalled beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(pixel_out) && $stable(frame_last)))
    else $error("stalled result beat changed");

endmodule

bind max_filter_3x3 mf3_checker #(.PIXEL_BITS(PIXEL_BITS)) u_mf3_checker (.*);
